// ===== hdl/light_link_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// light link frame receiver assertion macros
// shorthand for the concurrent checks on the receiver ports
// ----------------------------------------------------------------------------
`ifndef LIGHT_LINK_FRAME_RECEIVER_DEFINES_SVH
`define LIGHT_LINK_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define LLFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define LLFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define LLFR_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/llfr_pkg.sv =====
// ----------------------------------------------------------------------------
// llfr_pkg
// widths, register indexes, reset values and types of the frame receiver
// ----------------------------------------------------------------------------
package llfr_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int DATA_W     = 4;
  localparam int PRE_W      = 4;
  localparam int MARGIN_W   = 10;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PREAMBLE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NOISE_MARGIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_MEAN = 2'd2;

  // reset values
  localparam logic [PRE_W-1:0]    RST_PREAMBLE     = 4'd5;
  localparam logic [MARGIN_W-1:0] RST_NOISE_MARGIN = 10'd5;
  localparam logic [SAMPLE_W-1:0] RST_INITIAL_MEAN = 10'd520;

  typedef struct packed {
    logic              emit;
    logic [DATA_W-1:0] data_word;
    logic              accepted;
  } frame_res_t;

endpackage

// ===== hdl/llfr_mean.sv =====
// ----------------------------------------------------------------------------
// llfr_mean
// block mean tracker: sums a window of samples, divides on the extra sample
// ----------------------------------------------------------------------------
module llfr_mean #(
  parameter int AVG_WINDOW = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [llfr_pkg::SAMPLE_W-1:0] sample,
  input  logic                          load_en,
  input  logic [llfr_pkg::SAMPLE_W-1:0] load_value,
  output logic [llfr_pkg::SAMPLE_W-1:0] mean_cur
);

  localparam int SUM_W   = llfr_pkg::SAMPLE_W + $clog2(AVG_WINDOW);
  localparam int CNT_W   = $clog2(AVG_WINDOW + 1);
  localparam int LOG_W   = $clog2(AVG_WINDOW);
  localparam int SHIFT   = SUM_W + LOG_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // ceil(2^SHIFT / AVG_WINDOW) gives an exact floor quotient for any sum
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << SHIFT) + longint'(AVG_WINDOW) - 1) / longint'(AVG_WINDOW));

  logic [SUM_W-1:0]               window_sum;
  logic [CNT_W-1:0]               window_count;
  logic [llfr_pkg::SAMPLE_W-1:0]  mean_level;
  logic [PROD_W-1:0]              prod;
  logic [llfr_pkg::SAMPLE_W-1:0]  quotient;
  logic                           window_full;

  assign window_full = (window_count == CNT_W'(AVG_WINDOW));
  assign prod        = PROD_W'(window_sum) * PROD_W'(RECIP);
  assign quotient    = prod[SHIFT +: llfr_pkg::SAMPLE_W];
  assign mean_cur    = window_full ? quotient : mean_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      window_count <= '0;
      mean_level   <= llfr_pkg::RST_INITIAL_MEAN;
    end else begin
      if (advance) begin
        if (window_full) begin
          mean_level   <= quotient;
          window_sum   <= '0;
          window_count <= '0;
        end else begin
          window_sum   <= window_sum + SUM_W'(sample);
          window_count <= window_count + CNT_W'(1);
        end
      end
      if (load_en) begin
        mean_level <= load_value;
      end
    end
  end

endmodule

// ===== hdl/llfr_framer.sv =====
// ----------------------------------------------------------------------------
// llfr_framer
// slicer, preamble search, data capture and frame checks
// ----------------------------------------------------------------------------
module llfr_framer #(
  parameter int FRAME_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [llfr_pkg::SAMPLE_W-1:0] sample,
  input  logic [llfr_pkg::SAMPLE_W-1:0] mean_cur,
  input  logic [llfr_pkg::PRE_W-1:0]    preamble,
  input  logic [llfr_pkg::MARGIN_W-1:0] margin,
  output llfr_pkg::frame_res_t          res
);

  localparam int IDX_W = (FRAME_BITS > 4) ? $clog2(FRAME_BITS) : 2;
  localparam int EXT_W = (FRAME_BITS > llfr_pkg::DATA_W) ? FRAME_BITS : llfr_pkg::DATA_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);
  localparam logic [IDX_W-1:0] PRE_LAST = IDX_W'(llfr_pkg::PRE_W - 1);
  localparam logic [1:0]       PRE_TOP  = 2'(llfr_pkg::PRE_W - 1);

  logic                          capturing;
  logic [IDX_W-1:0]              bit_index;
  logic [FRAME_BITS-1:0]         captured_bits;
  logic                          bit_val;
  logic                          expect_bit;
  logic [FRAME_BITS-1:0]         cap_shift;
  logic [EXT_W-1:0]              cap_ext;
  logic                          pairs_ok;
  logic [llfr_pkg::SAMPLE_W-1:0] distance;

  assign bit_val    = (sample > mean_cur);
  assign expect_bit = preamble[PRE_TOP - bit_index[1:0]];
  assign cap_shift  = {captured_bits[FRAME_BITS-2:0], bit_val};
  assign cap_ext    = EXT_W'(cap_shift);
  assign distance   = (sample > mean_cur) ? (sample - mean_cur) : (mean_cur - sample);

  // bits pair up in arrival order, oldest bit at the top
  always_comb begin
    pairs_ok = ((FRAME_BITS % 2) == 0);
    for (int k = 0; k < FRAME_BITS / 2; k++) begin
      if (cap_shift[FRAME_BITS-1-2*k] != cap_shift[FRAME_BITS-2-2*k]) begin
        pairs_ok = 1'b0;
      end
    end
  end

  always_comb begin
    res.emit      = capturing && (bit_index == LAST_IDX);
    res.data_word = cap_ext[llfr_pkg::DATA_W-1:0];
    res.accepted  = pairs_ok && !(^cap_shift) && (distance >= margin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing     <= 1'b0;
      bit_index     <= '0;
      captured_bits <= '0;
    end else if (advance) begin
      if (!capturing) begin
        if (bit_val == expect_bit) begin
          if (bit_index == PRE_LAST) begin
            capturing     <= 1'b1;
            bit_index     <= '0;
            captured_bits <= '0;
          end else begin
            bit_index <= bit_index + IDX_W'(1);
          end
        end else begin
          bit_index <= '0;
        end
      end else begin
        captured_bits <= cap_shift;
        if (bit_index == LAST_IDX) begin
          capturing <= 1'b0;
          bit_index <= '0;
        end else begin
          bit_index <= bit_index + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/light_link_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// light_link_frame_receiver
// on-off keyed light receiver with block-mean threshold and preamble search
// ----------------------------------------------------------------------------
//  channel  | dir | signals                          | content
//  ---------+-----+----------------------------------+---------------------------
//  s_axis   | in  | s_tvalid s_tready s_tdata[15:0]  | one sensor sample per word
//  m_axis   | out | m_tvalid m_tready m_tdata[7:0]   | one word per captured frame
//           |     | m_tuser                          | frame check passed
//  cfg      | in  | cfg_we cfg_addr cfg_wdata        | preamble, margin, init mean
//
//  one sample per cycle sustained while no frame word is stalled; a sample is
//  processed while it sits in the input register, and a closing sample loads
//  its frame word into the result register as it is processed. the path is the
//  window-sum reciprocal multiply, the slice compare and the frame checks.
//  rst is synchronous and clears the valid flags, the mean and framer state and config.
//  a stalled result only holds back a sample that would produce another one.
// ----------------------------------------------------------------------------
module light_link_frame_receiver #(
  parameter int AVG_WINDOW = 20,
  parameter int FRAME_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  // sample stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [llfr_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] sample
  // frame stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [llfr_pkg::M_TDATA_W-1:0]  m_tdata,   // [3:0] data_word
  output logic                            m_tuser,   // [0] accepted
  // register writes
  input  logic                            cfg_we,
  input  logic [llfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [llfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // input register
  logic                          in_v;
  logic [llfr_pkg::SAMPLE_W-1:0] in_sample;

  // result register
  logic                          out_v;
  logic [llfr_pkg::DATA_W-1:0]   out_data;
  logic                          out_acc;

  // config registers
  logic [llfr_pkg::PRE_W-1:0]    preamble;
  logic [llfr_pkg::MARGIN_W-1:0] margin;

  logic                          advance;
  logic                          out_free;
  logic                          mean_load;
  logic [llfr_pkg::SAMPLE_W-1:0] mean_cur;
  llfr_pkg::frame_res_t          res;

  // a sample that ends a frame waits only for a free result slot
  assign out_free  = !out_v || m_tready;
  assign advance   = in_v && (!res.emit || out_free);
  assign s_tready  = !in_v || advance;
  assign mean_load = cfg_we && (cfg_addr == llfr_pkg::REG_INITIAL_MEAN);

  assign m_tvalid = out_v;
  assign m_tdata  = llfr_pkg::M_TDATA_W'(out_data);
  assign m_tuser  = out_acc;

  llfr_mean #(
    .AVG_WINDOW (AVG_WINDOW)
  ) u_mean (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .sample     (in_sample),
    .load_en    (mean_load),
    .load_value (cfg_wdata[llfr_pkg::SAMPLE_W-1:0]),
    .mean_cur   (mean_cur)
  );

  llfr_framer #(
    .FRAME_BITS (FRAME_BITS)
  ) u_framer (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .sample   (in_sample),
    .mean_cur (mean_cur),
    .preamble (preamble),
    .margin   (margin),
    .res      (res)
  );

  // input register, refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[llfr_pkg::SAMPLE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance && res.emit) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_data <= res.data_word;
      out_acc  <= res.accepted;
    end
  end

  // config writes; unused index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble <= llfr_pkg::RST_PREAMBLE;
      margin   <= llfr_pkg::RST_NOISE_MARGIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        llfr_pkg::REG_PREAMBLE:     preamble <= cfg_wdata[llfr_pkg::PRE_W-1:0];
        llfr_pkg::REG_NOISE_MARGIN: margin   <= cfg_wdata[llfr_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/llfr_checker.sv =====
// ----------------------------------------------------------------------------
// llfr_checker
// port-level checks on the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "light_link_frame_receiver_defines.svh"

module llfr_checker #(
  parameter int FRAME_BITS = 4
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [llfr_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                            m_tuser
);

  // stalled frame word holds
  `LLFR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "frame word changed under stall")

  // reset empties the result register
  `LLFR_ASSERT_RST(a_rst_empty, rst, !m_tvalid, "frame word present after reset")

  // a new frame word follows the sample that closed it through the input and result registers
  `LLFR_ASSERT_IMP(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "frame word without closing sample")

  // an accepted frame has equal bit pairs
  `LLFR_ASSERT_IMP(a_pairs, m_tvalid && m_tuser, ((FRAME_BITS % 2) == 0) && (m_tdata[3] == m_tdata[2]) && (m_tdata[1] == m_tdata[0]), "accepted frame with unequal pair")

endmodule

bind light_link_frame_receiver llfr_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_llfr_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);
